// ===== design/ctf_pkg.sv =====
// ----------------------------------------------------------------------------
// ctf_pkg: shared types and constants for the complementary tilt filter
// Angle format, register indexes, CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ctf_pkg;

  localparam int CordicStepsDef   = 16;
  localparam int AngleFracBitsDef = 8;
  localparam int MaxSteps         = 24;

  localparam int AngW   = 18;
  localparam int ZW     = 27;   // degrees, 16 fraction bits, holds +-2^10 deg
  localparam int XYW    = 28;   // 16 bit input * 256, growth by CORDIC gain

  localparam logic signed [AngW-1:0] AngMax = 18'sd131071;
  localparam logic signed [AngW-1:0] AngMin = -18'sd131072;

  localparam logic [2:0] RegGyroBiasX    = 3'd0;
  localparam logic [2:0] RegGyroBiasY    = 3'd1;
  localparam logic [2:0] RegTiltPitchBias = 3'd2;
  localparam logic [2:0] RegTiltRollBias = 3'd3;
  localparam logic [2:0] RegPitchSetpoint = 3'd4;
  localparam logic [2:0] RegRateGain     = 3'd5;

  typedef struct packed {
    logic signed [XYW-1:0] x;
    logic signed [XYW-1:0] y;
    logic signed [ZW-1:0]  z;
  } vec_t;

  function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      5'd0:  r = 27'sd2949120;
      5'd1:  r = 27'sd1740967;
      5'd2:  r = 27'sd919879;
      5'd3:  r = 27'sd466945;
      5'd4:  r = 27'sd234379;
      5'd5:  r = 27'sd117304;
      5'd6:  r = 27'sd58666;
      5'd7:  r = 27'sd29335;
      5'd8:  r = 27'sd14668;
      5'd9:  r = 27'sd7334;
      5'd10: r = 27'sd3667;
      5'd11: r = 27'sd1833;
      5'd12: r = 27'sd917;
      5'd13: r = 27'sd458;
      5'd14: r = 27'sd229;
      5'd15: r = 27'sd115;
      5'd16: r = 27'sd57;
      5'd17: r = 27'sd29;
      5'd18: r = 27'sd14;
      5'd19: r = 27'sd7;
      5'd20: r = 27'sd4;
      5'd21: r = 27'sd2;
      5'd22: r = 27'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [AngW-1:0] sat_ang(input logic signed [31:0] v);
    logic signed [AngW-1:0] r;
    if (v > 32'(AngMax)) r = AngMax;
    else if (v < 32'(AngMin)) r = AngMin;
    else r = v[AngW-1:0];
    return r;
  endfunction

endpackage

// ===== design/ctf_cell.sv =====
// ----------------------------------------------------------------------------
// ctf_cell: one CORDIC vectoring cell
// Registers a vector pair and performs one micro-rotation per step.
// ----------------------------------------------------------------------------
module ctf_cell #(
  parameter int unsigned Step = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  ctf_pkg::vec_t vec_i,
  output ctf_pkg::vec_t vec_o
);
  import ctf_pkg::*;

  vec_t vec_q, vec_d;

  always_comb begin
    vec_d = vec_i;
    if (vec_i.y >= 0) begin
      vec_d.x = vec_i.x + (vec_i.y >>> Step);
      vec_d.y = vec_i.y - (vec_i.x >>> Step);
      vec_d.z = vec_i.z + atan_deg(5'(Step));
    end else begin
      vec_d.x = vec_i.x - (vec_i.y >>> Step);
      vec_d.y = vec_i.y + (vec_i.x >>> Step);
      vec_d.z = vec_i.z - atan_deg(5'(Step));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_q <= '0;
    end else if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign vec_o = vec_q;

endmodule

// ===== design/ctf_chain.sv =====
// ----------------------------------------------------------------------------
// ctf_chain: row of CORDIC cells computing atan2 in degrees
// Quadrant fold at the entry, rounding to the angle format at the exit.
// ----------------------------------------------------------------------------
module ctf_chain #(
  parameter int unsigned CordicSteps   = ctf_pkg::CordicStepsDef,
  parameter int unsigned AngleFracBits = ctf_pkg::AngleFracBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic signed [15:0]             y_i,
  input  logic signed [15:0]             x_i,
  output logic signed [ctf_pkg::AngW-1:0] ang_o
);
  import ctf_pkg::*;

  localparam int unsigned N  = (CordicSteps > MaxSteps) ? MaxSteps : CordicSteps;
  localparam int unsigned Sh = 16 - AngleFracBits;

  vec_t v [N+1];
  logic zero_q [N+1];
  vec_t fold;
  logic fold_zero;
  logic signed [XYW-1:0] xs, ys;
  logic signed [ZW-1:0] zr;

  always_comb begin
    xs = XYW'(x_i) <<< 8;
    ys = XYW'(y_i) <<< 8;
    fold.z = '0;
    if (x_i < 0) begin
      fold.z = (y_i >= 0) ? ZW'(180 * 65536) : -ZW'(180 * 65536);
      xs = -xs;
      ys = -ys;
    end
    fold.x = xs;
    fold.y = ys;
    fold_zero = (x_i == 0) && (y_i == 0);
  end

  assign v[0]      = fold;
  assign zero_q[0] = fold_zero;

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic zq;
    ctf_cell #(.Step(g)) u_cell (
      .clk_i, .rst_ni, .en_i, .vec_i(v[g]), .vec_o(v[g+1])
    );
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) zq <= 1'b0;
      else if (en_i) zq <= zero_q[g];
    end
    assign zero_q[g+1] = zq;
  end

  assign zr = (v[N].z + ZW'(1 << (Sh - 1))) >>> Sh;
  assign ang_o = zero_q[N] ? '0 : zr[AngW-1:0];

endmodule

// ===== design/complementary_tilt_filter_top.sv =====
// ----------------------------------------------------------------------------
// complementary_tilt_filter_top: pitch and roll complementary filter
// One IMU sample in, one pitch/roll pair out.
// ----------------------------------------------------------------------------
// Each sample request runs through two CORDIC cell rows (pitch and roll) that
// advance one cell per cycle, then a gyro multiply, a tilt sum, a blend by
// 1/5 and a result register. The next request is taken only after the
// result has been accepted, one sample at a time. Register writes are taken
// only while idle.
module complementary_tilt_filter_top #(
  parameter int unsigned CordicSteps   = ctf_pkg::CordicStepsDef,
  parameter int unsigned AngleFracBits = ctf_pkg::AngleFracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [15:0]            accel_x_i,
  input  logic signed [15:0]            accel_y_i,
  input  logic signed [15:0]            accel_z_i,
  input  logic signed [15:0]            gyro_rate_x_i,
  input  logic signed [15:0]            gyro_rate_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [ctf_pkg::AngW-1:0] pitch_angle_o,
  output logic signed [ctf_pkg::AngW-1:0] roll_angle_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [2:0]                    cfg_index_i,
  input  logic [23:0]                   cfg_data_i
);
  import ctf_pkg::*;

  localparam int unsigned N  = (CordicSteps > MaxSteps) ? MaxSteps : CordicSteps;
  localparam int unsigned GSh = 24 - AngleFracBits;
  localparam int unsigned CntW = $clog2(N + 6);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_RUN = 4'b0010, S_POST = 4'b0100, S_OUT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q;
  logic [2:0] post_q;

  logic signed [15:0] gbx_q, gby_q;
  logic signed [16:0] tpb_q, trb_q, psp_q;
  logic [23:0] gain_q;
  logic signed [AngW-1:0] pest_q, rest_q;
  logic first_q;

  logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q;
  logic signed [AngW-1:0] tp_ang, tr_ang;
  logic signed [16:0] dgx_q, dgy_q;
  logic signed [41:0] prx_q, pry_q;
  logic signed [AngW-1:0] pint_q, rint_q, ptilt_q, rtilt_q;
  logic signed [AngW-1:0] pres_q, rres_q;
  logic signed [41:0] prx_r, pry_r;
  logic signed [31:0] sp, sr;
  logic signed [AngW-1:0] bp, br;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign pitch_angle_o = pres_q;
  assign roll_angle_o  = rres_q;

  ctf_chain #(.CordicSteps(CordicSteps), .AngleFracBits(AngleFracBits)) u_pitch (
    .clk_i, .rst_ni, .en_i(1'b1), .y_i(ay_q), .x_i(az_q), .ang_o(tp_ang)
  );
  ctf_chain #(.CordicSteps(CordicSteps), .AngleFracBits(AngleFracBits)) u_roll (
    .clk_i, .rst_ni, .en_i(1'b1), .y_i(ax_q), .x_i(az_q), .ang_o(tr_ang)
  );

  // blend: floor((8e + 2t + 5) / 10) = floor((4e + t + 2.5)/5)
  function automatic logic signed [AngW-1:0] blend5(input logic signed [AngW-1:0] e,
                                                     input logic signed [AngW-1:0] t);
    logic signed [23:0] s;
    logic signed [47:0] m;
    logic signed [23:0] q;
    logic signed [23:0] r;
    s = 24'(e) * 24'sd8 + 24'(t) * 24'sd2 + 24'sd5;
    m = 48'(s) * 48'sd419431;             // ~2^22/10
    q = 24'(m >>> 22);
    r = s - q * 24'sd10;
    if (r < 0) q = q - 24'sd1;
    else if (r >= 24'sd10) q = q + 24'sd1;
    return sat_ang(32'(q));
  endfunction

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_RUN;
      S_RUN:  if (cnt_q == CntW'(N)) state_d = S_POST;
      S_POST: if (post_q == 3'd2) state_d = S_OUT;
      S_OUT:  if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign prx_r = (prx_q + (42'sd1 <<< (GSh - 1))) >>> GSh;
  assign pry_r = (pry_q + (42'sd1 <<< (GSh - 1))) >>> GSh;
  assign sp = 32'(tp_ang) - 32'(tpb_q) + 32'(psp_q);
  assign sr = 32'(tr_ang) - 32'(trb_q);
  assign bp = blend5(pint_q, ptilt_q);
  assign br = blend5(rint_q, rtilt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      post_q  <= '0;
      gbx_q   <= '0;
      gby_q   <= '0;
      tpb_q   <= '0;
      trb_q   <= '0;
      psp_q   <= 17'sd23040;
      gain_q  <= 24'd2561;
      pest_q  <= '0;
      rest_q  <= '0;
      first_q <= 1'b1;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          RegGyroBiasX:     gbx_q  <= cfg_data_i[15:0];
          RegGyroBiasY:     gby_q  <= cfg_data_i[15:0];
          RegTiltPitchBias: tpb_q  <= cfg_data_i[16:0];
          RegTiltRollBias:  trb_q  <= cfg_data_i[16:0];
          RegPitchSetpoint: psp_q  <= cfg_data_i[16:0];
          RegRateGain:      gain_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == S_IDLE) cnt_q <= '0;
      else if (state_q == S_RUN) cnt_q <= cnt_q + 1'b1;
      if (state_q == S_RUN) post_q <= '0;
      else if (state_q == S_POST) post_q <= post_q + 1'b1;
      if (state_q == S_POST && post_q == 3'd2) begin
        pest_q  <= first_q ? ptilt_q : bp;
        rest_q  <= first_q ? rtilt_q : br;
        first_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ax_q <= accel_x_i;
      ay_q <= accel_y_i;
      az_q <= accel_z_i;
      gx_q <= gyro_rate_x_i;
      gy_q <= gyro_rate_y_i;
    end
    dgx_q <= 17'(gx_q) - 17'(gbx_q);
    dgy_q <= 17'(gy_q) - 17'(gby_q);
    prx_q <= 42'(dgx_q) * $signed({18'd0, gain_q});
    pry_q <= 42'(dgy_q) * $signed({18'd0, gain_q});
    if (state_q == S_POST && post_q == 3'd0) begin
      pint_q  <= sat_ang(32'(pest_q) + 32'(prx_r));
      rint_q  <= sat_ang(32'(rest_q) + 32'(pry_r));
    end
    if (state_q == S_POST && post_q == 3'd1) begin
      ptilt_q <= sat_ang(sp);
      rtilt_q <= sat_ang(sr);
    end
    if (state_q == S_POST && post_q == 3'd2) begin
      pres_q <= first_q ? ptilt_q : bp;
      rres_q <= first_q ? rtilt_q : br;
    end
  end

  a_no_in_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o) else $error("ready while busy");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(pres_q)))
    else $error("result dropped");
  a_first_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |-> !first_q) else $error("first flag stuck");

endmodule

// ===== test/complementary_tilt_filter_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complementary_tilt_filter_top_tb: self-checking bench for the tilt filter
// Drives IMU sample requests and register writes into the filter. A local
// fixed-point model of the gyro integration, the CORDIC tilt and the blend
// predicts each pitch/roll pair, which is compared with the block's output.
// Bursty input, a patterned output stall, a long output hold-off and a drain
// pause are included.
// ----------------------------------------------------------------------------
module complementary_tilt_filter_top_tb;
  import ctf_pkg::*;

  localparam int    NumRandom = 750;
  localparam int    Watchdog  = 20000;
  localparam int    Latency   = 40;
  localparam logic [2:0] RegUnused = 3'd6;

  typedef struct {
    logic signed [15:0] ax, ay, az, gx, gy;
    logic               known;
    logic signed [17:0] pitch, roll;
  } sample_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i, cfg_valid_i, cfg_ready_o;
  logic signed [15:0] accel_x_i, accel_y_i, accel_z_i, gyro_rate_x_i, gyro_rate_y_i;
  logic signed [17:0] pitch_angle_o, roll_angle_o;
  logic [2:0]  cfg_index_i;
  logic [23:0] cfg_data_i;

  complementary_tilt_filter_top uut (.*);

  longint bias_gx, bias_gy, bias_tp, bias_tr, setpoint, gain;
  longint est_pitch, est_roll;
  bit     awaiting_first;
  bit     in_held;

  typedef struct { logic signed [17:0] pitch, roll; logic known;
                   logic signed [17:0] kp, kr; } angle_pair_t;
  angle_pair_t pending_angles[$];

  int     errors, idle_cycles, hold_off;
  bit     stall_on;
  longint atan_tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                           29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                           29, 14, 7, 4, 2, 1, 0};

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rshift(longint v, int s);
    return (s == 0) ? v : fshift(v + (64'sd1 <<< (s - 1)), s);
  endfunction

  function automatic longint sat18(longint v);
    return (v > 131071) ? 131071 : (v < -131072) ? -131072 : v;
  endfunction

  function automatic longint tilt_deg(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x *= 256;
    y *= 256;
    if (x < 0) begin
      z = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CordicStepsDef; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_tab[i];
      end else begin
        x -= dx; y += dy; z -= atan_tab[i];
      end
    end
    return rshift(z, 16 - AngleFracBitsDef);
  endfunction

  function automatic longint blend5(longint e, longint t);
    longint n, q;
    n = 2 * (4 * e + t) + 5;
    q = n / 10;
    if (n % 10 != 0 && n < 0) q--;
    return sat18(q);
  endfunction

  task automatic predict_angles(input sample_t s);
    longint p, r, tp, tr;
    angle_pair_t a;
    p  = sat18(est_pitch + rshift((longint'(s.gx) - bias_gx) * gain, 16));
    r  = sat18(est_roll + rshift((longint'(s.gy) - bias_gy) * gain, 16));
    tp = sat18(tilt_deg(s.ay, s.az) - bias_tp + setpoint);
    tr = sat18(tilt_deg(s.ax, s.az) - bias_tr);
    if (awaiting_first) begin
      p = tp; r = tr; awaiting_first = 0;
    end else begin
      p = blend5(p, tp); r = blend5(r, tr);
    end
    est_pitch = p;
    est_roll  = r;
    a.pitch = p; a.roll = r; a.known = s.known; a.kp = s.pitch; a.kr = s.roll;
    pending_angles.push_back(a);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // output side: check and stall pattern
  always @(posedge clk_i) begin
    angle_pair_t a;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_angles.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        a = pending_angles.pop_front();
        if (pitch_angle_o !== a.pitch) report_mismatch("pitch", pitch_angle_o, a.pitch);
        if (roll_angle_o !== a.roll) report_mismatch("roll", roll_angle_o, a.roll);
        if (a.known && pitch_angle_o !== a.kp) report_mismatch("pitch table", pitch_angle_o, a.kp);
        if (a.known && roll_angle_o !== a.kr) report_mismatch("roll table", roll_angle_o, a.kr);
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off--;
      out_ready_i <= 1'b0;
    end else begin
      if ($urandom_range(0, 15) == 0) stall_on = ~stall_on;
      out_ready_i <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles = 0;
    else if (++idle_cycles >= Watchdog) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input longint v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v[23:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegGyroBiasX:     bias_gx  = longint'($signed(v[15:0]));
      RegGyroBiasY:     bias_gy  = longint'($signed(v[15:0]));
      RegTiltPitchBias: bias_tp  = longint'($signed(v[16:0]));
      RegTiltRollBias:  bias_tr  = longint'($signed(v[16:0]));
      RegPitchSetpoint: setpoint = longint'($signed(v[16:0]));
      RegRateGain:      gain     = longint'(v[23:0]);
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pending_angles.size() != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  // Send one request; valid stays high when another follows back to back.
  task automatic send_sample(input sample_t s, input bit keep);
    if (!in_held) @(negedge clk_i);
    in_valid_i    <= 1'b1;
    accel_x_i     <= s.ax;
    accel_y_i     <= s.ay;
    accel_z_i     <= s.az;
    gyro_rate_x_i <= s.gx;
    gyro_rate_y_i <= s.gy;
    do @(posedge clk_i); while (!in_ready_o);
    predict_angles(s);
    @(negedge clk_i);
    if (!keep) in_valid_i <= 1'b0;
    in_held = keep;
  endtask

  function automatic logic signed [15:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 16)) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.ax = rand_field(); s.ay = rand_field(); s.az = rand_field();
    s.gx = rand_field(); s.gy = rand_field();
    s.known = 0; s.pitch = 0; s.roll = 0;
    return s;
  endfunction

  sample_t stim_table[] = '{
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 18'sd23040, 18'sd0},
    '{16'sd0, 16'sd0, 16'sd1000, 16'sd0, 16'sd0, 1'b1, 18'sd23040, 18'sd0},
    '{16'sd0, 16'sd0, -16'sd1000, 16'sd0, 16'sd0, 1'b0, 18'sd0, 18'sd0},
    '{16'sd100, -16'sd100, 16'sd0, 16'sd0, 16'sd0, 1'b0, 18'sd0, 18'sd0},
    '{-16'sd100, 16'sd100, 16'sd0, 16'sd0, 16'sd0, 1'b0, 18'sd0, 18'sd0},
    '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, 18'sd0, 18'sd0},
    '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 18'sd0, 18'sd0},
    '{16'sh7fff, 16'sh8000, -16'sd1, 16'sh8000, 16'sh7fff, 1'b0, 18'sd0, 18'sd0},
    '{16'sh8000, 16'sh7fff, 16'sd1, -16'sd1, 16'sd1, 1'b0, 18'sd0, 18'sd0},
    '{-16'sd5, 16'sd5, -16'sd5, 16'sd0, 16'sd0, 1'b0, 18'sd0, 18'sd0},
    '{16'sd3, -16'sd4, 16'sd0, 16'sd200, -16'sd200, 1'b0, 18'sd0, 18'sd0}
  };

  initial begin
    sample_t s;
    int burst;
    rst_ni = 1'b0; in_valid_i = 1'b0; out_ready_i = 1'b0; cfg_valid_i = 1'b0;
    cfg_index_i = '0; cfg_data_i = '0;
    accel_x_i = '0; accel_y_i = '0; accel_z_i = '0; gyro_rate_x_i = '0; gyro_rate_y_i = '0;
    errors = 0; idle_cycles = 0; hold_off = 0; stall_on = 0; in_held = 0;
    bias_gx = 0; bias_gy = 0; bias_tp = 0; bias_tr = 0; setpoint = 23040; gain = 2561;
    est_pitch = 0; est_roll = 0; awaiting_first = 1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (stim_table[i]) send_sample(stim_table[i], 0);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(RegGyroBiasX, 32767); write_reg(RegGyroBiasY, -32768);
          write_reg(RegRateGain, 24'hffffff);
        end
        1: begin
          write_reg(RegGyroBiasX, -32768); write_reg(RegGyroBiasY, 32767);
          write_reg(RegTiltPitchBias, 46080); write_reg(RegTiltRollBias, -46080);
          write_reg(RegPitchSetpoint, -46080); write_reg(RegRateGain, 0);
        end
        2: begin
          write_reg(RegTiltPitchBias, -46080); write_reg(RegTiltRollBias, 46080);
          write_reg(RegPitchSetpoint, 46080); write_reg(RegRateGain, 1);
        end
        3: write_reg(RegUnused, $urandom);
        default: begin
          write_reg(RegGyroBiasX, $urandom_range(0, 400) - 200);
          write_reg(RegGyroBiasY, $urandom_range(0, 400) - 200);
          write_reg(RegTiltPitchBias, $urandom_range(0, 92160) - 46080);
          write_reg(RegTiltRollBias, $urandom_range(0, 92160) - 46080);
          write_reg(RegPitchSetpoint, $urandom_range(0, 92160) - 46080);
          write_reg(RegRateGain, $urandom_range(0, 20000));
        end
      endcase
      if (phase == 2) hold_off = 300;
      for (int n = 0; n < NumRandom / 6;) begin
        burst = (phase == 2 && n == 0) ? 20 : $urandom_range(1, 12);
        for (int b = 0; b < burst && n < NumRandom / 6; b++, n++) begin
          s = rand_sample();
          send_sample(s, (b < burst - 1) && (n + 1 < NumRandom / 6));
        end
        if (phase == 4 && n > 60 && n < 75) drain();
        repeat ($urandom_range(0, 8)) @(negedge clk_i);
      end
      drain();
    end

    fork
      begin
        drain();
      end
      begin
        repeat (Watchdog) @(posedge clk_i);
      end
    join_any
    disable fork;
    if (errors == 0 && pending_angles.size() == 0) begin
      $display("SUCCESS");
    end else begin
      if (pending_angles.size() != 0)
        report_mismatch("left over", pending_angles.size(), 0);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
